### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SVM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define SVM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### hdl/svm_pkg.sv
// ----------------------------------------------------------------------------
// Supply voltage monitor package
// Widths, constants and register indexes shared by the monitor and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package svm_pkg;

    localparam int SAMPLE_W   = 10;
    localparam int SUM_W      = 12;
    localparam int AVG_W      = SUM_W - 2;
    localparam int CUTOFF_W   = 14;
    localparam int MV_W       = 14;
    localparam int SUPPLY_W   = 13;
    localparam int DIVIDEND_W = 21;
    localparam int DIVISOR_W  = AVG_W;
    localparam int PROD_W     = AVG_W + SUPPLY_W;
    localparam int MV_SHIFT   = 9;
    localparam int CFG_IDX_W  = 2;

    localparam logic [DIVIDEND_W-1:0] BANDGAP_SCALE  = 21'd1125300;
    localparam logic [AVG_W-1:0]      REF_LOW_LIMIT  = 10'd225;
    localparam logic [SUPPLY_W-1:0]   REF_LOW_SUPPLY = 13'd4999;
    localparam logic [CUTOFF_W-1:0]   VIN_CUTOFF_RST = 14'd4500;
    localparam logic [CUTOFF_W-1:0]   BAT_CUTOFF_RST = 14'd3400;
    localparam logic [1:0]            LAST_ROUND     = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_VIN_CUTOFF = 2'd0,
        REG_BAT_CUTOFF = 2'd1
    } cfg_index_t;

endpackage

`default_nettype wire

### hdl/svm_divider.sv
// ----------------------------------------------------------------------------
// Restoring divider
// Produces one quotient bit per cycle; the quotient is truncated to the
// supply width, which holds for every divisor the monitor hands in.
// ----------------------------------------------------------------------------
`default_nettype none

module svm_divider (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [svm_pkg::DIVIDEND_W-1:0]  dividend,
    input  wire logic [svm_pkg::DIVISOR_W-1:0]   divisor,
    output logic                                 done,
    output logic [svm_pkg::SUPPLY_W-1:0]         quotient
);
    import svm_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    // The partial remainder stays below the divisor, so one extra bit suffices.
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[SUPPLY_W-1:0];

endmodule

`default_nettype wire

### hdl/supply_voltage_monitor.sv
// ----------------------------------------------------------------------------
// Supply voltage monitor
// Averages four rounds of battery, input and bandgap samples, derives the
// chip supply from the bandgap and scales the other two into millivolts.
//
//   Channel   Direction  Handshake             Payload
//   input     in         in_valid / in_ready   battery_sample, vin_sample,
//                                              ref_sample
//   result    out        out_valid / out_ready battery_mv, vin_mv, supply_mv,
//                                              power_ok, battery_ok
//   config    in         cfg_we                cfg_index, cfg_data
//
// The first three rounds of a block only add to the sums. The fourth holds the
// input off while the block runs through the divide state (21 restoring steps
// and a check of the divider's done flag), a multiply state per voltage on the
// shared multiplier and a load of the result register; a low reference skips
// the divider. Reset clears the sums and the round count and restores the
// cutoffs to their defaults. A stalled result holds the last step until the
// output register frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module supply_voltage_monitor (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [svm_pkg::SAMPLE_W-1:0]  battery_sample,
    input  wire logic [svm_pkg::SAMPLE_W-1:0]  vin_sample,
    input  wire logic [svm_pkg::SAMPLE_W-1:0]  ref_sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [svm_pkg::MV_W-1:0]           battery_mv,
    output logic [svm_pkg::MV_W-1:0]           vin_mv,
    output logic [svm_pkg::SUPPLY_W-1:0]       supply_mv,
    output logic                               power_ok,
    output logic                               battery_ok,
    input  wire logic                          cfg_we,
    input  wire logic [svm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [svm_pkg::CUTOFF_W-1:0]  cfg_data
);
    import svm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_MUL_B = 5'b00100,
        ST_MUL_V = 5'b01000,
        ST_LOAD  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           round_reg, round_next;
    logic [SUM_W-1:0]     bat_sum_reg, bat_sum_next;
    logic [SUM_W-1:0]     vin_sum_reg, vin_sum_next;
    logic [SUM_W-1:0]     ref_sum_reg, ref_sum_next;
    logic [CUTOFF_W-1:0]  vin_cutoff_reg, vin_cutoff_next;
    logic [CUTOFF_W-1:0]  bat_cutoff_reg, bat_cutoff_next;
    logic [SUPPLY_W-1:0]  supply_reg, supply_next;
    logic [MV_W-1:0]      bat_mv_reg, bat_mv_next;
    logic [MV_W-1:0]      vin_mv_reg, vin_mv_next;
    logic                 out_valid_reg, out_valid_next;
    logic [MV_W-1:0]      bat_out_reg, bat_out_next;
    logic [MV_W-1:0]      vin_out_reg, vin_out_next;
    logic [SUPPLY_W-1:0]  sup_out_reg, sup_out_next;
    logic                 pwr_ok_reg, pwr_ok_next;
    logic                 bat_ok_reg, bat_ok_next;

    logic                 in_fire;
    logic                 out_free;
    logic [SUM_W-1:0]     ref_sum_add;
    logic [AVG_W-1:0]     ref_avg_add;
    logic                 div_start;
    logic                 div_done;
    logic [SUPPLY_W-1:0]  div_quo;
    logic [AVG_W-1:0]     mul_a;
    logic [PROD_W-1:0]    mul_prod;

    assign in_ready    = (state_reg == ST_IDLE);
    assign in_fire     = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign ref_sum_add = ref_sum_reg + SUM_W'(ref_sample);
    assign ref_avg_add = ref_sum_add[SUM_W-1:2];

    // The divider starts on the fourth round unless the reference is too low.
    assign div_start = in_fire && (round_reg == LAST_ROUND) && (ref_avg_add >= REF_LOW_LIMIT);

    svm_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (BANDGAP_SCALE),
        .divisor  (ref_avg_add),
        .done     (div_done),
        .quotient (div_quo)
    );

    // One multiplier serves both scaled voltages in turn.
    assign mul_a    = (state_reg == ST_MUL_B) ? bat_sum_reg[SUM_W-1:2] : vin_sum_reg[SUM_W-1:2];
    assign mul_prod = PROD_W'(mul_a) * PROD_W'(supply_reg);

    always_comb
    begin
        vin_cutoff_next = vin_cutoff_reg;
        bat_cutoff_next = bat_cutoff_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VIN_CUTOFF: vin_cutoff_next = cfg_data;
                REG_BAT_CUTOFF: bat_cutoff_next = cfg_data;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        bat_sum_next   = bat_sum_reg;
        vin_sum_next   = vin_sum_reg;
        ref_sum_next   = ref_sum_reg;
        supply_next    = supply_reg;
        bat_mv_next    = bat_mv_reg;
        vin_mv_next    = vin_mv_reg;
        out_valid_next = out_valid_reg && !out_ready;
        bat_out_next   = bat_out_reg;
        vin_out_next   = vin_out_reg;
        sup_out_next   = sup_out_reg;
        pwr_ok_next    = pwr_ok_reg;
        bat_ok_next    = bat_ok_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    bat_sum_next = bat_sum_reg + SUM_W'(battery_sample);
                    vin_sum_next = vin_sum_reg + SUM_W'(vin_sample);
                    ref_sum_next = ref_sum_add;
                    round_next   = round_reg + 1'b1;
                    if (round_reg == LAST_ROUND)
                    begin
                        if (div_start)
                        begin
                            state_next = ST_DIV;
                        end
                        else
                        begin
                            supply_next = REF_LOW_SUPPLY;
                            state_next  = ST_MUL_B;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    supply_next = div_quo;
                    state_next  = ST_MUL_B;
                end
            end
            ST_MUL_B:
            begin
                bat_mv_next = mul_prod[MV_SHIFT +: MV_W];
                state_next  = ST_MUL_V;
            end
            ST_MUL_V:
            begin
                vin_mv_next = mul_prod[MV_SHIFT +: MV_W];
                state_next  = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    bat_out_next   = bat_mv_reg;
                    vin_out_next   = vin_mv_reg;
                    sup_out_next   = supply_reg;
                    pwr_ok_next    = vin_mv_reg > vin_cutoff_reg;
                    bat_ok_next    = bat_mv_reg > bat_cutoff_reg;
                    bat_sum_next   = '0;
                    vin_sum_next   = '0;
                    ref_sum_next   = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            round_reg      <= '0;
            bat_sum_reg    <= '0;
            vin_sum_reg    <= '0;
            ref_sum_reg    <= '0;
            vin_cutoff_reg <= VIN_CUTOFF_RST;
            bat_cutoff_reg <= BAT_CUTOFF_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            round_reg      <= round_next;
            bat_sum_reg    <= bat_sum_next;
            vin_sum_reg    <= vin_sum_next;
            ref_sum_reg    <= ref_sum_next;
            vin_cutoff_reg <= vin_cutoff_next;
            bat_cutoff_reg <= bat_cutoff_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        supply_reg  <= supply_next;
        bat_mv_reg  <= bat_mv_next;
        vin_mv_reg  <= vin_mv_next;
        bat_out_reg <= bat_out_next;
        vin_out_reg <= vin_out_next;
        sup_out_reg <= sup_out_next;
        pwr_ok_reg  <= pwr_ok_next;
        bat_ok_reg  <= bat_ok_next;
    end

    assign out_valid  = out_valid_reg;
    assign battery_mv = bat_out_reg;
    assign vin_mv     = vin_out_reg;
    assign supply_mv  = sup_out_reg;
    assign power_ok   = pwr_ok_reg;
    assign battery_ok = bat_ok_reg;

    `SVM_ASSERT_IMP(a_supply_range, state_reg == ST_MUL_B,
                    (supply_reg >= 13'd1100) && (supply_reg <= 13'd5001))
    `SVM_ASSERT_IMP(a_sums_clear, (state_reg == ST_IDLE) && (round_reg == 2'd0),
                    (bat_sum_reg == '0) && (vin_sum_reg == '0) && (ref_sum_reg == '0))
    `SVM_ASSERT_NXT(a_div_to_mul, (state_reg == ST_DIV) && div_done, state_reg == ST_MUL_B)
    `SVM_ASSERT_IMP(a_flag_match, $rose(out_valid_reg),
                    (pwr_ok_reg == (vin_out_reg > vin_cutoff_reg)) &&
                    (bat_ok_reg == (bat_out_reg > bat_cutoff_reg)))

endmodule

`default_nettype wire
